// ----- src/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Word widths, register indexes, microcode format and program, and the
// modular add shared by the multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Port widths are fixed; WIDTH is the arithmetic word (8..64).
  localparam int PORT_W = 64;
  localparam int WIDTH  = 64;
  localparam int CNT_W  = $clog2(WIDTH);
  localparam int PC_W   = 3;
  localparam int IDX_W  = 2;

  localparam logic [WIDTH-1:0] WORD_ONE = WIDTH'(1);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_MODULUS  = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_EXPONENT = IDX_W'(1);

  // Microcode step kinds
  localparam logic [1:0] K_MUL     = 2'd0;
  localparam logic [1:0] K_BR_ZERO = 2'd1;
  localparam logic [1:0] K_BR_EVEN = 2'd2;
  localparam logic [1:0] K_DONE    = 2'd3;

  // Multiplier A operand sources
  localparam logic [1:0] SRC_OPND = 2'd0;
  localparam logic [1:0] SRC_ONE  = 2'd1;
  localparam logic [1:0] SRC_PROD = 2'd2;
  localparam logic [1:0] SRC_BASE = 2'd3;

  // Multiplier B operand sources
  localparam logic B_ONE  = 1'b0;
  localparam logic B_BASE = 1'b1;

  // Destinations
  localparam logic DST_PROD = 1'b0;
  localparam logic DST_BASE = 1'b1;

  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      src_a;
    logic            src_b;
    logic            dst;
    logic            shift_exp;
    logic            jmp;
    logic [PC_W-1:0] target;
  } uop_t;

  typedef struct packed {
    logic             go;
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic             busy;
    logic [WIDTH-1:0] product;
  } mul_rsp_t;

  // Program:
  //   0: base <- operand * 1 mod n   (reduce operand)
  //   1: prod <- 1 * 1 mod n
  //   2: exponent zero -> 6
  //   3: exponent bit clear -> 5
  //   4: prod <- prod * base mod n
  //   5: base <- base * base mod n, shift exponent, -> 2
  //   6: deliver prod
  function automatic uop_t ucode_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{kind: K_DONE, src_a: SRC_ONE, src_b: B_ONE, dst: DST_PROD,
          shift_exp: 1'b0, jmp: 1'b0, target: '0};
    case (pc)
      PC_W'(0): begin
        u.kind = K_MUL; u.src_a = SRC_OPND; u.src_b = B_ONE; u.dst = DST_BASE;
      end
      PC_W'(1): begin
        u.kind = K_MUL; u.src_a = SRC_ONE; u.src_b = B_ONE; u.dst = DST_PROD;
      end
      PC_W'(2): begin
        u.kind = K_BR_ZERO; u.target = PC_W'(6);
      end
      PC_W'(3): begin
        u.kind = K_BR_EVEN; u.target = PC_W'(5);
      end
      PC_W'(4): begin
        u.kind = K_MUL; u.src_a = SRC_PROD; u.src_b = B_BASE; u.dst = DST_PROD;
      end
      PC_W'(5): begin
        u.kind = K_MUL; u.src_a = SRC_BASE; u.src_b = B_BASE; u.dst = DST_BASE;
        u.shift_exp = 1'b1; u.jmp = 1'b1; u.target = PC_W'(2);
      end
      default: begin
        u.kind = K_DONE;
      end
    endcase
    return u;
  endfunction

  // (a + b) mod n for b < n
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] n);
    logic [WIDTH-1:0] gap;
    gap = n - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

endpackage

// ----- src/mexp_mulmod.sv -----
// ----------------------------------------------------------------------------
// Interleaved modular multiplier
// Bit-serial, MSB first: one doubling step per bit of a, plus one add step
// when that bit is set. One modular add per cycle.
// ----------------------------------------------------------------------------
module mexp_mulmod (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mexp_pkg::mul_req_t             req,
  input  logic [mexp_pkg::WIDTH-1:0]     modulus,
  output mexp_pkg::mul_rsp_t             rsp
);
  import mexp_pkg::*;

  localparam logic PH_DBL = 1'b0;
  localparam logic PH_ADD = 1'b1;

  logic             run_r;
  logic             done_r;
  logic             phase_r;
  logic [CNT_W-1:0] cnt_r;
  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] a_r;
  logic [WIDTH-1:0] b_r;
  logic             advance;

  assign advance = run_r && ((phase_r == PH_ADD) || !a_r[WIDTH-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= PH_DBL;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r   <= 1'b1;
        phase_r <= PH_DBL;
      end else if (run_r) begin
        if (phase_r == PH_DBL && a_r[WIDTH-1]) begin
          phase_r <= PH_ADD;
        end else begin
          phase_r <= PH_DBL;
        end
        if (advance && cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      acc_r <= '0;
      a_r   <= req.a;
      b_r   <= req.b;
      cnt_r <= CNT_W'(WIDTH - 1);
    end else if (run_r) begin
      if (phase_r == PH_DBL) begin
        acc_r <= add_mod(acc_r, acc_r, modulus);
      end else begin
        acc_r <= add_mod(acc_r, b_r, modulus);
      end
      if (advance) begin
        a_r   <= a_r << 1;
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  assign rsp.done    = done_r;
  assign rsp.busy    = run_r;
  assign rsp.product = acc_r;

endmodule

// ----- src/modular_exponentiation_core.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Right-to-left square-and-multiply, driven by a small microcode program
// over one shared bit-serial modular multiplier.
//
//   channel  ports                                   handshake
//   input    start, busy, in_operand_word            start && !busy
//   result   out_valid, out_power_residue            one-cycle strobe
//   config   cfg_we, cfg_index, cfg_wdata            cfg_we, no wait
//
// Each multiplication runs on the serial multiplier after a launch step: a
// doubling step per bit of its first operand and an add step per set bit.
// An item takes two multiplications to load, then for each exponent bit up
// to the highest set one a squaring and, for set bits, a product step, plus
// two branch steps per bit.
// Reset is synchronous: modulus returns to 1, exponent to 0, core idle.
// The receiver cannot stall: a result is shown for one cycle only.
// ----------------------------------------------------------------------------
module modular_exponentiation_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [mexp_pkg::PORT_W-1:0]    in_operand_word,
  output logic                           out_valid,
  output logic [mexp_pkg::PORT_W-1:0]    out_power_residue,
  input  logic                           cfg_we,
  input  logic [mexp_pkg::IDX_W-1:0]     cfg_index,
  input  logic [mexp_pkg::PORT_W-1:0]    cfg_wdata
);
  import mexp_pkg::*;

  logic [WIDTH-1:0]  modulus_r;
  logic [WIDTH-1:0]  exponent_r;
  logic              busy_r;
  logic              wait_r;
  logic [PC_W-1:0]   pc_r;
  logic              out_valid_r;
  logic [WIDTH-1:0]  result_r;
  logic [WIDTH-1:0]  opnd_r;
  logic [WIDTH-1:0]  prod_r;
  logic [WIDTH-1:0]  base_r;
  logic [WIDTH-1:0]  exp_r;
  logic [PC_W-1:0]   pc_nxt;
  uop_t              uop;
  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;
  logic              mul_finish;
  logic [WIDTH-1:0]  cfg_val;

  assign cfg_val = cfg_wdata[WIDTH-1:0];

  // Configuration registers; a zero modulus is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= WORD_ONE;
      exponent_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODULUS: begin
          if (cfg_val != '0) begin
            modulus_r <= cfg_val;
          end
        end
        CFG_EXPONENT: begin
          exponent_r <= cfg_val;
        end
        default: begin
        end
      endcase
    end
  end

  assign uop        = ucode_rom(pc_r);
  assign mul_finish = busy_r && uop.kind == K_MUL && wait_r && mul_rsp.done;

  always_comb begin
    pc_nxt = pc_r + PC_W'(1);
    case (uop.kind)
      K_MUL: begin
        if (uop.jmp) begin
          pc_nxt = uop.target;
        end
      end
      K_BR_ZERO: begin
        if (exp_r == '0) begin
          pc_nxt = uop.target;
        end
      end
      K_BR_EVEN: begin
        if (!exp_r[0]) begin
          pc_nxt = uop.target;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mul_req.go = busy_r && uop.kind == K_MUL && !wait_r;
    case (uop.src_a)
      SRC_OPND: mul_req.a = opnd_r;
      SRC_ONE:  mul_req.a = WORD_ONE;
      SRC_PROD: mul_req.a = prod_r;
      SRC_BASE: mul_req.a = base_r;
      default:  mul_req.a = WORD_ONE;
    endcase
    mul_req.b = (uop.src_b == B_BASE) ? base_r : WORD_ONE;
  end

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .modulus (modulus_r),
    .rsp     (mul_rsp)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      wait_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          pc_r   <= '0;
        end
      end else begin
        case (uop.kind)
          K_MUL: begin
            if (!wait_r) begin
              wait_r <= 1'b1;
            end else if (mul_rsp.done) begin
              wait_r <= 1'b0;
              pc_r   <= pc_nxt;
            end
          end
          K_BR_ZERO, K_BR_EVEN: begin
            pc_r <= pc_nxt;
          end
          K_DONE: begin
            out_valid_r <= 1'b1;
            busy_r      <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath words
  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      opnd_r <= in_operand_word[WIDTH-1:0];
      exp_r  <= exponent_r;
    end else if (mul_finish) begin
      if (uop.dst == DST_BASE) begin
        base_r <= mul_rsp.product;
      end else begin
        prod_r <= mul_rsp.product;
      end
      if (uop.shift_exp) begin
        exp_r <= exp_r >> 1;
      end
    end
    if (busy_r && uop.kind == K_DONE) begin
      result_r <= prod_r;
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_power_residue = PORT_W'(result_r);

`ifndef ASSERT_OFF
  a_start_enters_program: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy_r |=> busy_r && pc_r == '0)
    else $error("accepted item did not enter the program at step zero");

  a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy_r && $past(busy_r))
    else $error("result strobe without a finishing item");

  a_mul_launch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.go |-> !mul_rsp.busy)
    else $error("multiplier launched while running");

  a_mul_done_awaited: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> wait_r && busy_r)
    else $error("multiplier finished with no step waiting");
`endif

endmodule

// ----- sim/tb_modular_exponentiation_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for modular_exponentiation_core
// Loads a series of key settings (modulus and exponent) while the core is
// idle, sends operand words in random bursts and compares every strobed
// residue with a square-and-multiply predictor built on wide integer math.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_core;
  import mexp_pkg::*;

  localparam int IDLE_LIMIT   = 100000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 10;

  localparam logic [IDX_W-1:0]  CFG_SPARE_2 = IDX_W'(2);
  localparam logic [IDX_W-1:0]  CFG_SPARE_3 = IDX_W'(3);
  localparam logic [PORT_W-1:0] WORD_MASK   = PORT_W'({WIDTH{1'b1}});
  localparam logic [PORT_W-1:0] ALL_ONES    = '1;
  localparam logic [PORT_W-1:0] TOP_BIT     = {1'b1, {(PORT_W-1){1'b0}}};
  localparam logic [PORT_W-1:0] PRIME_64    = 64'hFFFF_FFFF_FFFF_FFC5;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [PORT_W-1:0] in_operand_word = '0;
  logic              out_valid;
  logic [PORT_W-1:0] out_power_residue;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [PORT_W-1:0] cfg_wdata = '0;

  // Key registers as the core should hold them
  logic [PORT_W-1:0] key_modulus = PORT_W'(1);
  logic [PORT_W-1:0] key_exponent = '0;

  logic [PORT_W-1:0] operand_q[$];
  logic [PORT_W-1:0] residue_q[$];
  logic [PORT_W-1:0] residue_want;
  int                error_count = 0;
  int                idle_cycles = 0;
  int                burst_left = 0;
  int                gap_left = 0;

  modular_exponentiation_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operand_word   (in_operand_word),
    .out_valid         (out_valid),
    .out_power_residue (out_power_residue),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [PORT_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [PORT_W-1:0] mul_mod_word(input logic [PORT_W-1:0] a,
                                                     input logic [PORT_W-1:0] b,
                                                     input logic [PORT_W-1:0] n);
    logic [2*PORT_W-1:0] prod;
    prod = {{PORT_W{1'b0}}, a} * {{PORT_W{1'b0}}, b};
    return PORT_W'(prod % {{PORT_W{1'b0}}, n});
  endfunction

  function automatic logic [PORT_W-1:0] power_residue_of(input logic [PORT_W-1:0] operand);
    logic [PORT_W-1:0] n;
    logic [PORT_W-1:0] base;
    logic [PORT_W-1:0] acc;
    logic [PORT_W-1:0] bits;
    n    = key_modulus & WORD_MASK;
    base = (operand & WORD_MASK) % n;
    acc  = PORT_W'(1) % n;
    bits = key_exponent & WORD_MASK;
    while (bits != '0) begin
      if (bits[0]) acc = mul_mod_word(acc, base, n);
      bits = bits >> 1;
      base = mul_mod_word(base, base, n);
    end
    return acc;
  endfunction

  function automatic logic [PORT_W-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return PORT_W'($urandom_range(0, 3));
      1: return key_modulus - PORT_W'(1);
      2: return key_modulus;
      3: return key_modulus + PORT_W'(1);
      default: return rand_word();
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    error_count++;
  endtask

  // Leaves cfg_we high; close_writes lowers it after the last write.
  task automatic write_key(input logic [IDX_W-1:0] idx, input logic [PORT_W-1:0] value);
    logic [PORT_W-1:0] v;
    v = value & WORD_MASK;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_MODULUS: begin
        if (v != '0) key_modulus = v;
      end
      CFG_EXPONENT: begin
        key_exponent = v;
      end
      default: begin
      end
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_keys(input logic [PORT_W-1:0] modulus, input logic [PORT_W-1:0] exponent);
    write_key(CFG_MODULUS, modulus);
    write_key(CFG_EXPONENT, exponent);
    close_writes();
  endtask

  task automatic wait_idle();
    while (operand_q.size() != 0 || start || residue_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_items(input int count);
    repeat (count) operand_q.push_back(pick_operand());
    wait_idle();
  endtask

  // Driver: hold start until the core takes the item, then burst or pause.
  always @(posedge clk) begin
    if (!rst_n) begin
      start           <= 1'b0;
      in_operand_word <= '0;
    end else begin
      if (start && !busy) begin
        residue_q.push_back(power_residue_of(in_operand_word));
        void'(operand_q.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 6);
          case ($urandom_range(0, 9))
            0, 1, 2: gap_left = 0;
            9:       gap_left = $urandom_range(100, 400);
            default: gap_left = $urandom_range(1, 40);
          endcase
        end
      end
      if (!(start && busy)) begin
        if (gap_left == 0 && operand_q.size() != 0) begin
          start           <= 1'b1;
          in_operand_word <= operand_q[0];
        end else begin
          if (gap_left > 0) gap_left--;
          start           <= 1'b0;
          in_operand_word <= rand_word();
        end
      end
    end
  end

  // Monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (residue_q.size() == 0) begin
          report_mismatch($sformatf("residue %h with no item pending", out_power_residue));
        end else begin
          residue_want = residue_q.pop_front();
          if (out_power_residue !== residue_want)
            report_mismatch($sformatf("residue %h, want %h", out_power_residue, residue_want));
        end
      end
      if (out_valid || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [PORT_W-1:0] mod_pick;
    logic [PORT_W-1:0] exp_pick;
    int                width_pick;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset keys: modulus 1 with zero exponent gives zero
    operand_q.push_back('0);
    operand_q.push_back(ALL_ONES);
    wait_idle();

    set_keys(ALL_ONES, '0);
    operand_q.push_back('0);
    operand_q.push_back(ALL_ONES);
    operand_q.push_back(PORT_W'(5));
    wait_idle();

    // Full-length exponent
    write_key(CFG_EXPONENT, ALL_ONES);
    close_writes();
    operand_q.push_back('0);
    operand_q.push_back(PORT_W'(1));
    operand_q.push_back(ALL_ONES);
    operand_q.push_back(TOP_BIT);
    operand_q.push_back(rand_word());
    wait_idle();

    set_keys(PRIME_64, PORT_W'(1));
    operand_q.push_back(ALL_ONES);
    operand_q.push_back(PRIME_64 - PORT_W'(1));
    operand_q.push_back(PRIME_64);
    operand_q.push_back(rand_word());
    wait_idle();

    // Zero modulus and unused indexes must leave the keys alone
    write_key(CFG_MODULUS, '0);
    write_key(CFG_SPARE_2, rand_word());
    write_key(CFG_SPARE_3, ALL_ONES);
    write_key(CFG_EXPONENT, PORT_W'(65537));
    close_writes();
    run_items(3);

    set_keys(PORT_W'(2), PORT_W'(3));
    operand_q.push_back('0);
    operand_q.push_back(PORT_W'(1));
    operand_q.push_back(ALL_ONES);
    wait_idle();

    // Random keys; keep exponents short except in one phase
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0:       mod_pick = rand_word();
        1:       mod_pick = PORT_W'($urandom_range(1, 255));
        2:       mod_pick = {32'b0, $urandom};
        default: mod_pick = ALL_ONES - PORT_W'($urandom_range(0, 1000));
      endcase
      if (phase == 3) begin
        exp_pick = rand_word();
      end else if ($urandom_range(0, 5) == 0) begin
        exp_pick = '0;
      end else begin
        width_pick = $urandom_range(1, 20);
        exp_pick = (rand_word() & ((PORT_W'(1) << width_pick) - PORT_W'(1)))
                   | (PORT_W'(1) << (width_pick - 1));
      end
      if ($urandom_range(0, 3) == 0) write_key(CFG_SPARE_2, rand_word());
      set_keys(mod_pick, exp_pick);
      run_items(PHASE_ITEMS);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/mexp_pkg.sv
src/mexp_mulmod.sv
src/modular_exponentiation_core.sv
sim/tb_modular_exponentiation_core.sv
